/* src/sem_pkg.sv */
`default_nettype none

package sem_pkg;

  // Widest image row that the line memory holds.
  localparam int MAX_WIDTH = 2048;
  // Row width after reset.
  localparam int RESET_WIDTH = 640;
  // Narrowest row that still has a full 3x3 window.
  localparam int MIN_WIDTH = 3;

  localparam int PIX_W = 8;
  localparam int LW_W = 12;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EFFW_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = EFFW_W + 1;
  localparam int ROW_W = 2;
  localparam logic [ROW_W-1:0] ROW_FULL = ROW_W'(2);

  // Output queue between the datapath and the master port.
  localparam int FIFO_DEPTH = 3;
  localparam int FPTR_W = $clog2(FIFO_DEPTH);
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [PIX_W-1:0] MAG_MAX = PIX_W'(255);

  typedef logic [PIX_W-1:0] pixel_t;

  // One column of the 3x3 window, oldest row at the top.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // One entry of the line memory: the pixels two rows up and one row up.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
  } line_pair_t;

  typedef struct packed {
    pixel_t magnitude;
    logic   row_end;
  } result_t;

endpackage

`default_nettype wire

/* src/sobel_edge_magnitude_3x3.sv */
// A result passes through the second stage and the output queue before it is
//   presented on the master port.
// Throughput: one pixel per clock while the output queue has room, set by the line
//   memory, which is read once and written once per pixel.
// Reset: clears the row and column counters, the output queue and the second-stage
//   valid flag, and sets the row width to 640. The line memory is not cleared.
`default_nettype none

module sobel_edge_magnitude_3x3
  import sem_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // Configuration: row width in pixels, written whenever cfg_write is high.
  input  wire logic             cfg_write,
  input  wire logic [LW_W-1:0]  cfg_data,
  // Pixel stream.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel
  input  wire logic             s_axis_tuser,   // [0] frame_start
  // Edge magnitude stream.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] magnitude
  output logic                  m_axis_tlast    // row_end
);

  // The effective row width is kept already clamped into the legal range, so
  // the end-of-row compare on the input side is a single add and compare.
  logic [EFFW_W-1:0] eff_width;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic             in_beat;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             last_cur;
  logic             emit_cur;

  // Second stage: the accepted beat, waiting for its line memory word.
  logic             s1_valid;
  pixel_t           s1_pixel;
  logic [COL_W-1:0] s1_addr;
  logic             s1_emit;
  logic             s1_last;

  line_pair_t  rd_pair;
  line_pair_t  wr_pair;
  column_t     col_cur_win;
  column_t     col_prev;
  column_t     col_old;
  pixel_t      magnitude;
  result_t     push_data;
  result_t     head_data;
  logic [FCNT_W-1:0] fifo_count;
  logic        fifo_push;

  // A beat is taken only when the output queue has room for every result that
  // may still be in flight, so the second stage never has to stall.
  assign s_axis_tready = ((FCNT_W+1)'(fifo_count) + (FCNT_W+1)'(s1_valid))
                         < (FCNT_W+1)'(FIFO_DEPTH);
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A frame start restarts the counts before the pixel is placed. A column at or
  // beyond the width (possible after a width change mid-row) closes the row.
  always_comb begin
    col_cur  = s_axis_tuser ? '0 : column_count;
    row_cur  = s_axis_tuser ? '0 : row_count;
    last_cur = ((CMP_W'(col_cur) + CMP_W'(1)) >= CMP_W'(eff_width));
    emit_cur = (row_cur == ROW_FULL) && (col_cur >= COL_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width    <= EFFW_W'(RESET_WIDTH);
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_data < LW_W'(MIN_WIDTH)) begin
          eff_width <= EFFW_W'(MIN_WIDTH);
        end else if (32'(cfg_data) > MAX_WIDTH) begin
          eff_width <= EFFW_W'(MAX_WIDTH);
        end else begin
          eff_width <= EFFW_W'(cfg_data);
        end
      end
      if (in_beat) begin
        if (last_cur) begin
          column_count <= '0;
          row_count    <= (row_cur == ROW_FULL) ? row_cur : row_cur + ROW_W'(1);
        end else begin
          column_count <= col_cur + COL_W'(1);
          row_count    <= row_cur;
        end
      end
      s1_valid <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pixel <= s_axis_tdata;
      s1_addr  <= col_cur;
      s1_emit  <= emit_cur;
      s1_last  <= last_cur;
    end
  end

  // The line memory is read on the accepting edge and written back from the second
  // stage in the following cycle. Inside a frame the same column is read again only
  // a whole row later, so the write always lands before the read that depends on it.
  assign wr_pair.top = rd_pair.mid;
  assign wr_pair.mid = s1_pixel;

  sem_line_store u_line_store (
    .clk     (clk),
    .rd_en   (in_beat),
    .rd_addr (col_cur),
    .rd_data (rd_pair),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_pair)
  );

  // The newest window column is formed from the memory word and the pixel
  // itself. Two cells hold the two columns before it and shift once per pixel.
  assign col_cur_win.top = rd_pair.top;
  assign col_cur_win.mid = rd_pair.mid;
  assign col_cur_win.bot = s1_pixel;

  sem_column_cell u_cell_prev (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_cur_win),
    .col_out (col_prev)
  );

  sem_column_cell u_cell_old (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_prev),
    .col_out (col_old)
  );

  sem_gradient u_gradient (
    .col_old   (col_old),
    .col_prev  (col_prev),
    .col_cur   (col_cur_win),
    .magnitude (magnitude)
  );

  assign fifo_push           = s1_valid && s1_emit;
  assign push_data.magnitude = magnitude;
  assign push_data.row_end   = s1_last;

  sem_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (push_data),
    .pop       (m_axis_tready),
    .not_empty (m_axis_tvalid),
    .head_data (head_data),
    .count     (fifo_count)
  );

  assign m_axis_tdata = head_data.magnitude;
  assign m_axis_tlast = head_data.row_end;

endmodule

`default_nettype wire

/* src/sem_line_store.sv */
`default_nettype none

module sem_line_store
  import sem_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output line_pair_t            rd_data,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  line_pair_t            wr_data
);

  // Both buffered rows share one word per column.
  line_pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/sem_column_cell.sv */
`default_nettype none

module sem_column_cell
  import sem_pkg::*;
(
  input  wire logic clk,
  input  wire logic shift,
  input  column_t   col_in,
  output column_t   col_out
);

  // Holds one window column and passes it on to the next cell on each shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

`default_nettype wire

/* src/sem_gradient.sv */
`default_nettype none

module sem_gradient
  import sem_pkg::*;
(
  input  column_t col_old,
  input  column_t col_prev,
  input  column_t col_cur,
  output pixel_t  magnitude
);

  localparam int SUM_W = PIX_W + 2;
  localparam int DIF_W = SUM_W + 1;

  logic [SUM_W-1:0] right_sum, left_sum, bot_sum, top_sum;
  logic signed [DIF_W-1:0] gx, gy;
  logic [SUM_W-1:0] abs_gx, abs_gy;
  logic [SUM_W:0] mag_sum;

  always_comb begin
    right_sum = SUM_W'(col_cur.top) + {1'b0, col_cur.mid, 1'b0} + SUM_W'(col_cur.bot);
    left_sum  = SUM_W'(col_old.top) + {1'b0, col_old.mid, 1'b0} + SUM_W'(col_old.bot);
    bot_sum   = SUM_W'(col_old.bot) + {1'b0, col_prev.bot, 1'b0} + SUM_W'(col_cur.bot);
    top_sum   = SUM_W'(col_old.top) + {1'b0, col_prev.top, 1'b0} + SUM_W'(col_cur.top);

    gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});

    abs_gx = gx[DIF_W-1] ? SUM_W'(-gx) : SUM_W'(gx);
    abs_gy = gy[DIF_W-1] ? SUM_W'(-gy) : SUM_W'(gy);

    mag_sum = (SUM_W+1)'(abs_gx) + (SUM_W+1)'(abs_gy);
    if (mag_sum > (SUM_W+1)'(MAG_MAX)) begin
      magnitude = MAG_MAX;
    end else begin
      magnitude = mag_sum[PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* src/sem_out_fifo.sv */
`default_nettype none

module sem_out_fifo
  import sem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  result_t                push_data,
  input  wire logic              pop,
  output logic                   not_empty,
  output result_t                head_data,
  output logic [FCNT_W-1:0]      count
);

  result_t entries [FIFO_DEPTH];
  logic [FPTR_W-1:0] head, tail;
  logic do_pop;

  assign not_empty = (count != '0);
  assign head_data = entries[head];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : tail + FPTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : head + FPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + FCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - FCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
